// ===== design/lzwd_pkg.sv =====
// ----------------------------------------------------------------------------
// lzwd_pkg
// Shared types and constants of the LZ window decompressor.
// ----------------------------------------------------------------------------
package lzwd_pkg;

    localparam int DIST_W = 13;     // back distance after ring reduction
    localparam int LEN_W  = 9;      // copy length, up to 256

    localparam logic [15:0] FLAG_EMPTY  = 16'h8000;
    localparam logic [7:0]  FLAG_MARK   = 8'h80;
    localparam logic [13:0] LONG_BASE   = 14'h2000;
    localparam logic [13:0] SHORT_BASE  = 14'd256;

    typedef enum logic [2:0] {
        CMD_LIT  = 3'b001,
        CMD_COPY = 3'b010,
        CMD_END  = 3'b100
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind          kind;
        logic [7:0]         data;
        logic [LEN_W-1:0]   len;
        logic [DIST_W-1:0]  back_dist;
    } t_cmd;

    typedef enum logic [8:0] {
        PH_FLAG1 = 9'b000000001,
        PH_FLAG2 = 9'b000000010,
        PH_FLAG3 = 9'b000000100,
        PH_FLAG4 = 9'b000001000,
        PH_LIT   = 9'b000010000,
        PH_HI    = 9'b000100000,
        PH_LO    = 9'b001000000,
        PH_EXT   = 9'b010000000,
        PH_SHORT = 9'b100000000
    } t_phase;

endpackage

// ===== design/lz_window_decompressor_core.sv =====
// ----------------------------------------------------------------------------
// lz_window_decompressor_core
// LZSS stream decompressor with a ring window, parser and copy engine split.
// ----------------------------------------------------------------------------
// Parser steps: a data byte passes accept, flag reload, one step per flag
//   bit (up to 4), the token step, then for a copy the ring reduction
//   steps (dist / WINDOW_SIZE + 1), and a push step.
//   Copies take a ring read, then a write, per output byte, plus one pop
//   per command.
// Reset: synchronous, active low; afterwards the ring is zeroed one address
//   at a time, during which no input beat is taken.
// ----------------------------------------------------------------------------
//
// Structure:
//   lzwd_front  - takes input beats, tracks flag bits and token phase, builds
//                 one command (literal, copy, end) per literal byte or token.
//   lzwd_fifo   - four deep command queue, lets parser and engine stall apart.
//   lzwd_back   - owns the ring RAM, byte counter and size limit, packs up to
//                 four bytes per output beat in a registered output stage.
// Writing the size register re-arms everything but the ring contents and a pending output beat.
module lz_window_decompressor_core #(
    parameter int WINDOW_SIZE = 8192
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_byte0,
    output logic [7:0]  o_byte1,
    output logic [7:0]  o_byte2,
    output logic [7:0]  o_byte3,
    output logic [2:0]  o_byte_count,
    output logic        o_run_last,
    output logic        o_finished
);
    import lzwd_pkg::*;

    t_cmd  fr_cmd, q_cmd;
    logic  fr_push, q_full, q_valid, q_pop, clearing;

    lzwd_front #(.WINDOW_SIZE(WINDOW_SIZE)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_arm      (i_cfg_we),
        .i_hold     (clearing),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_byte  (i_in_byte),
        .o_push     (fr_push),
        .o_cmd      (fr_cmd),
        .i_full     (q_full)
    );

    lzwd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flush (i_cfg_we),
        .i_push  (fr_push),
        .i_data  (fr_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_cmd)
    );

    lzwd_back #(.WINDOW_SIZE(WINDOW_SIZE)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_cmd_valid  (q_valid),
        .i_cmd        (q_cmd),
        .o_pop        (q_pop),
        .o_clearing   (clearing),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_byte0      (o_byte0),
        .o_byte1      (o_byte1),
        .o_byte2      (o_byte2),
        .o_byte3      (o_byte3),
        .o_byte_count (o_byte_count),
        .o_run_last   (o_run_last),
        .o_finished   (o_finished)
    );
endmodule

// ===== design/lzwd_ram.sv =====
// ----------------------------------------------------------------------------
// lzwd_ram
// Generic simple dual-port RAM, one write port, registered read port.
// ----------------------------------------------------------------------------
module lzwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/lzwd_fifo.sv =====
// ----------------------------------------------------------------------------
// lzwd_fifo
// Four-entry command queue between parser and copy engine.
// ----------------------------------------------------------------------------
module lzwd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_flush,
    input  logic          i_push,
    input  lzwd_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output lzwd_pkg::t_cmd o_data
);
    import lzwd_pkg::*;

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    t_cmd           r_mem [DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [PW:0]    r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end
endmodule

// ===== design/lzwd_front.sv =====
// ----------------------------------------------------------------------------
// lzwd_front
// Stream parser: takes flag and data bytes, emits literal/copy/end commands.
// ----------------------------------------------------------------------------
module lzwd_front #(
    parameter int WINDOW_SIZE = 8192
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_arm,
    input  logic           i_hold,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic [7:0]     i_in_byte,
    output logic           o_push,
    output lzwd_pkg::t_cmd o_cmd,
    input  logic           i_full
);
    import lzwd_pkg::*;

    localparam logic [13:0] WIN = 14'(WINDOW_SIZE);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_WORK = 4'b0010,
        F_MOD  = 4'b0100,
        F_PUSH = 4'b1000
    } t_fstate;

    t_fstate           r_state, n_state;
    t_phase            r_phase, n_phase;
    logic [15:0]       r_flags, n_flags;
    logic [7:0]        r_byte,  n_byte;
    logic              r_used,  n_used;
    logic [7:0]        r_hi,    n_hi;
    logic [12:0]       r_off,   n_off;
    logic [LEN_W-1:0]  r_len,   n_len;
    logic [13:0]       r_dist,  n_dist;
    t_cmd              r_cmd,   n_cmd;
    logic [12:0]       off_new;
    logic              bit_now;

    assign o_in_ready = (r_state == F_IDLE) && !i_hold;
    assign o_cmd      = r_cmd;
    assign off_new    = {r_hi, r_byte[7:3]};
    assign bit_now    = r_flags[15];

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_flags = r_flags;
        n_byte  = r_byte;
        n_used  = r_used;
        n_hi    = r_hi;
        n_off   = r_off;
        n_len   = r_len;
        n_dist  = r_dist;
        n_cmd   = r_cmd;
        o_push  = 1'b0;
        case (r_state)
            F_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    n_byte  = i_in_byte;
                    n_used  = 1'b0;
                    n_state = F_WORK;
                end
            end
            F_WORK: begin
                case (r_phase)
                    PH_FLAG1, PH_FLAG2, PH_FLAG3, PH_FLAG4: begin
                        if (r_flags == FLAG_EMPTY) begin
                            // flags run dry: this byte refills them, or we wait for next
                            if (r_used) begin
                                n_state = F_IDLE;
                            end else begin
                                n_flags = {r_byte, FLAG_MARK};
                                n_used  = 1'b1;
                            end
                        end else begin
                            n_flags = {r_flags[14:0], 1'b0};
                            case (r_phase)
                                PH_FLAG1: n_phase = bit_now ? PH_LIT : PH_FLAG2;
                                PH_FLAG2: n_phase = bit_now ? PH_HI : PH_FLAG3;
                                PH_FLAG3: begin
                                    n_len   = bit_now ? LEN_W'(4) : LEN_W'(2);
                                    n_phase = PH_FLAG4;
                                end
                                default: begin
                                    n_len   = r_len + LEN_W'(bit_now);
                                    n_phase = PH_SHORT;
                                end
                            endcase
                        end
                    end
                    default: begin
                        if (r_used) begin
                            n_state = F_IDLE;
                        end else begin
                            n_used  = 1'b1;
                            n_phase = PH_FLAG1;
                            n_state = F_IDLE;
                            case (r_phase)
                                PH_LIT: begin
                                    n_cmd.kind      = CMD_LIT;
                                    n_cmd.data      = r_byte;
                                    n_cmd.len       = LEN_W'(1);
                                    n_cmd.back_dist = '0;
                                    n_state         = F_PUSH;
                                end
                                PH_HI: begin
                                    n_hi    = r_byte;
                                    n_phase = PH_LO;
                                end
                                PH_LO: begin
                                    n_off = off_new;
                                    if (r_byte[2:0] != 3'd0) begin
                                        n_len   = LEN_W'(r_byte[2:0]) + LEN_W'(2);
                                        n_dist  = LONG_BASE - {1'b0, off_new};
                                        n_state = F_MOD;
                                    end else begin
                                        n_phase = PH_EXT;
                                    end
                                end
                                PH_EXT: begin
                                    if (r_byte == 8'd0) begin
                                        n_cmd.kind      = CMD_END;
                                        n_cmd.data      = '0;
                                        n_cmd.len       = '0;
                                        n_cmd.back_dist = '0;
                                        n_state         = F_PUSH;
                                    end else begin
                                        n_len   = LEN_W'(r_byte) + LEN_W'(1);
                                        n_dist  = LONG_BASE - {1'b0, r_off};
                                        n_state = F_MOD;
                                    end
                                end
                                default: begin
                                    n_dist  = SHORT_BASE - {6'd0, r_byte};
                                    n_state = F_MOD;
                                end
                            endcase
                        end
                    end
                endcase
            end
            F_MOD: begin
                // reduce distance modulo the ring, one subtract per cycle
                if (r_dist >= WIN) begin
                    n_dist = r_dist - WIN;
                end else begin
                    n_cmd.kind      = CMD_COPY;
                    n_cmd.data      = '0;
                    n_cmd.len       = r_len;
                    n_cmd.back_dist = r_dist[DIST_W-1:0];
                    n_state         = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_arm) begin
            r_state <= F_IDLE;
            r_phase <= PH_FLAG1;
            r_flags <= FLAG_EMPTY;
            r_used  <= 1'b0;
            r_hi    <= '0;
            r_off   <= '0;
            r_len   <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_flags <= n_flags;
            r_used  <= n_used;
            r_hi    <= n_hi;
            r_off   <= n_off;
            r_len   <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_dist <= n_dist;
        r_cmd  <= n_cmd;
    end
endmodule

// ===== design/lzwd_back.sv =====
// ----------------------------------------------------------------------------
// lzwd_back
// Copy engine: runs commands through the ring, packs output beats.
// ----------------------------------------------------------------------------
module lzwd_back #(
    parameter int WINDOW_SIZE = 8192
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [15:0]    i_cfg_wdata,
    input  logic           i_cmd_valid,
    input  lzwd_pkg::t_cmd i_cmd,
    output logic           o_pop,
    output logic           o_clearing,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [7:0]     o_byte0,
    output logic [7:0]     o_byte1,
    output logic [7:0]     o_byte2,
    output logic [7:0]     o_byte3,
    output logic [2:0]     o_byte_count,
    output logic           o_run_last,
    output logic           o_finished
);
    import lzwd_pkg::*;

    localparam int AW = $clog2(WINDOW_SIZE);
    localparam logic [AW-1:0] LAST = AW'(WINDOW_SIZE - 1);
    localparam logic [AW:0]   WIN1 = (AW+1)'(WINDOW_SIZE);

    typedef enum logic [3:0] {
        B_CLEAR = 4'b0001,
        B_IDLE  = 4'b0010,
        B_RD    = 4'b0100,
        B_PUT   = 4'b1000
    } t_bstate;

    t_bstate           r_state, n_state;
    logic [AW-1:0]     r_clr,   n_clr;
    logic [15:0]       r_size;
    logic [15:0]       r_bw,    n_bw;
    logic [AW-1:0]     r_wp,    n_wp;
    logic [AW-1:0]     r_src,   n_src;
    logic [LEN_W-1:0]  r_rem,   n_rem;
    logic              r_done,  n_done;
    logic              r_mem_src, n_mem_src;
    logic [7:0]        r_byte,  n_byte;
    logic [1:0]        r_cnt,   n_cnt;
    logic [7:0]        r_lane [4];
    logic [7:0]        n_lane [4];
    logic [7:0]        merged [4];

    logic              r_ovalid;
    logic [7:0]        r_ob [4];
    logic [2:0]        r_ocnt;
    logic              r_olast, r_ofin;

    logic              push;
    logic [7:0]        p_b [4];
    logic [2:0]        p_cnt;
    logic              p_last, p_fin;

    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr;
    logic [7:0]        ram_wdata, ram_rdata;

    logic              can_push, hit, last;
    logic [7:0]        byte_in;
    logic [15:0]       bw_inc;
    logic [AW-1:0]     dm, src_calc, wp_inc, src_inc;

    lzwd_ram #(.WIDTH(8), .DEPTH(WINDOW_SIZE)) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_src),
        .o_rdata (ram_rdata)
    );

    assign can_push = !r_ovalid || i_out_ready;
    assign byte_in  = r_mem_src ? ram_rdata : r_byte;
    assign bw_inc   = r_bw + 16'd1;
    assign hit      = (bw_inc == r_size);
    assign last     = hit || (r_rem == LEN_W'(1));
    assign dm       = i_cmd.back_dist[AW-1:0];
    assign src_calc = (r_wp >= dm) ? (r_wp - dm)
                                   : AW'({1'b0, r_wp} + WIN1 - {1'b0, dm});
    assign wp_inc   = (r_wp == LAST) ? '0 : r_wp + 1'b1;
    assign src_inc  = (r_src == LAST) ? '0 : r_src + 1'b1;
    assign o_clearing = (r_state == B_CLEAR);

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            merged[k] = (2'(k) == r_cnt) ? byte_in : r_lane[k];
        end
    end

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_bw      = r_bw;
        n_wp      = r_wp;
        n_src     = r_src;
        n_rem     = r_rem;
        n_done    = r_done;
        n_mem_src = r_mem_src;
        n_byte    = r_byte;
        n_cnt     = r_cnt;
        for (int k = 0; k < 4; k++) begin
            n_lane[k] = r_lane[k];
            p_b[k]    = '0;
        end
        o_pop     = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = r_wp;
        ram_wdata = byte_in;
        push      = 1'b0;
        p_cnt     = '0;
        p_last    = 1'b0;
        p_fin     = 1'b0;
        case (r_state)
            B_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == LAST) n_state = B_IDLE;
            end
            B_IDLE: begin
                if (i_cmd_valid) begin
                    if (r_done || (r_bw >= r_size)) begin
                        o_pop = 1'b1;       // stream over: drop
                    end else begin
                        case (i_cmd.kind)
                            CMD_END: begin
                                if (can_push) begin
                                    o_pop  = 1'b1;
                                    push   = 1'b1;
                                    p_last = 1'b1;
                                    p_fin  = 1'b1;
                                    n_done = 1'b1;
                                end
                            end
                            CMD_LIT: begin
                                o_pop     = 1'b1;
                                n_byte    = i_cmd.data;
                                n_mem_src = 1'b0;
                                n_rem     = LEN_W'(1);
                                n_state   = B_PUT;
                            end
                            CMD_COPY: begin
                                o_pop     = 1'b1;
                                n_src     = src_calc;
                                n_rem     = i_cmd.len;
                                n_mem_src = 1'b1;
                                n_state   = B_RD;
                            end
                            default: o_pop = 1'b1;
                        endcase
                    end
                end
            end
            B_RD: begin
                ram_re  = 1'b1;
                n_state = B_PUT;
            end
            B_PUT: begin
                if (can_push) begin
                    n_bw = bw_inc;
                    n_lane[r_cnt] = byte_in;
                    // the byte that reaches the size is not kept in the ring
                    if (!hit) begin
                        ram_we = 1'b1;
                        n_wp   = wp_inc;
                    end
                    if ((r_cnt == 2'd3) || last) begin
                        push  = 1'b1;
                        p_cnt = {1'b0, r_cnt} + 3'd1;
                        for (int k = 0; k < 4; k++) begin
                            p_b[k] = (2'(k) <= r_cnt) ? merged[k] : 8'd0;
                        end
                        p_last = last;
                        p_fin  = hit;
                        n_cnt  = '0;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                    if (hit) n_done = 1'b1;
                    n_rem   = r_rem - 1'b1;
                    n_src   = src_inc;
                    n_state = last ? B_IDLE : B_RD;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_CLEAR;
            r_clr   <= '0;
            r_size  <= '0;
            r_bw    <= '0;
            r_wp    <= '0;
            r_done  <= 1'b0;
            r_cnt   <= '0;
            r_rem   <= '0;
        end else if (i_cfg_we) begin
            r_size  <= i_cfg_wdata;
            r_bw    <= '0;
            r_wp    <= '0;
            r_done  <= 1'b0;
            r_cnt   <= '0;
            r_clr   <= n_clr;
            r_rem   <= '0;
            r_state <= (r_state == B_CLEAR) ? n_state : B_IDLE;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_bw    <= n_bw;
            r_wp    <= n_wp;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
            r_rem   <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src     <= n_src;
        r_mem_src <= n_mem_src;
        r_byte    <= n_byte;
        for (int k = 0; k < 4; k++) begin
            r_lane[k] <= n_lane[k];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (push) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            for (int k = 0; k < 4; k++) begin
                r_ob[k] <= p_b[k];
            end
            r_ocnt  <= p_cnt;
            r_olast <= p_last;
            r_ofin  <= p_fin;
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_byte0      = r_ob[0];
    assign o_byte1      = r_ob[1];
    assign o_byte2      = r_ob[2];
    assign o_byte3      = r_ob[3];
    assign o_byte_count = r_ocnt;
    assign o_run_last   = r_olast;
    assign o_finished   = r_ofin;

    a_fin_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ofin) |-> r_olast)
        else $error("finished beat without run_last");
    a_empty_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && (r_ocnt == 3'd0)) |-> r_ofin)
        else $error("empty beat that is not the end notice");
    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_CLEAR) |-> !o_pop)
        else $error("command taken during ring clear");
    a_done_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && !i_cfg_we && !push && (r_state == B_IDLE)) |=> !push || r_done)
        else $error("output after stream end");
endmodule
